>>> rtl/bpe_pkg.sv
// Shared types and constants for the Bezier point evaluator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package bpe_pkg;

  // Width of the degree field and the number of control points carried per transaction.
  localparam int DEG_W      = 3;
  localparam int NUM_POINTS = 7;

  typedef logic [DEG_W-1:0] deg_t;

endpackage

`default_nettype wire

>>> rtl/bpe_if.sv
// Valid/ready channel interfaces for the Bezier point evaluator.
// Depends on bpe_pkg for the degree type.
`timescale 1ns / 1ps
`default_nettype none

interface bpe_in_if
  import bpe_pkg::*;
#(
  parameter int POINT_WIDTH = 32,
  parameter int T_FRAC_BITS = 16
);
  logic                          valid;
  logic                          ready;
  deg_t                          degree;
  logic signed [POINT_WIDTH-1:0] p0;
  logic signed [POINT_WIDTH-1:0] p1;
  logic signed [POINT_WIDTH-1:0] p2;
  logic signed [POINT_WIDTH-1:0] p3;
  logic signed [POINT_WIDTH-1:0] p4;
  logic signed [POINT_WIDTH-1:0] p5;
  logic signed [POINT_WIDTH-1:0] p6;
  logic [T_FRAC_BITS:0]          param_t;

  modport source (output valid, degree, p0, p1, p2, p3, p4, p5, p6, param_t, input ready);
  modport sink   (input valid, degree, p0, p1, p2, p3, p4, p5, p6, param_t, output ready);
endinterface

interface bpe_out_if #(
  parameter int POINT_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [POINT_WIDTH-1:0] curve_value;

  modport source (output valid, curve_value, input ready);
  modport sink   (input valid, curve_value, output ready);
endinterface

`default_nettype wire

>>> rtl/bpe_level.sv
// One de Casteljau round: NPTS points become NPTS-1 points, in two register stages
// (difference times t, then round and add). Depends on bpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpe_level
  import bpe_pkg::*;
#(
  parameter int PW    = 32,
  parameter int TFB   = 16,
  parameter int LEVEL = 0,
  parameter int NPTS  = 7
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     up_valid,
  output logic                          up_ready,
  input  wire logic [NPTS-1:0][PW-1:0]  up_pts,
  input  wire deg_t                     up_deg,
  input  wire logic [TFB:0]             up_t,
  output logic                          dn_valid,
  input  wire logic                     dn_ready,
  output logic [NPTS-2:0][PW-1:0]       dn_pts,
  output deg_t                          dn_deg,
  output logic [TFB:0]                  dn_t
);

  localparam int NL    = NPTS - 1;
  localparam int PRODW = PW + TFB + 3;
  localparam int STEPW = PW + 3;
  localparam logic [PRODW-1:0] HALF = PRODW'(1) << (TFB - 1);

  // Stage A: products
  logic                     va_r;
  logic                     act_r;
  deg_t                     deg_a_r;
  logic [TFB:0]             t_a_r;
  logic [NL-1:0][PW-1:0]    a_r;
  logic signed [PRODW-1:0]  prod_r   [NL];
  logic signed [PRODW-1:0]  prod_nxt [NL];
  logic signed [PW:0]       diff     [NL];
  logic signed [TFB+1:0]    t_s;
  logic                     ready_a;

  // Stage B: interpolated points
  logic                     vb_r;
  deg_t                     deg_b_r;
  logic [TFB:0]             t_b_r;
  logic [NL-1:0][PW-1:0]    pts_b_r;
  logic [NL-1:0][PW-1:0]    pts_b_nxt;
  logic signed [PRODW-1:0]  rnd      [NL];
  logic signed [STEPW-1:0]  sum      [NL];
  logic                     ready_b;

  assign ready_b  = !vb_r || dn_ready;
  assign ready_a  = !va_r || ready_b;
  assign up_ready = ready_a;

  assign t_s = $signed({1'b0, up_t});

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      diff[i]     = $signed({up_pts[i+1][PW-1], up_pts[i+1]})
                  - $signed({up_pts[i][PW-1], up_pts[i]});
      prod_nxt[i] = PRODW'(diff[i] * t_s);
    end
  end

  // Floor of (d*t + S/2) / S is an arithmetic shift of the rounded product.
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      rnd[i] = prod_r[i] + $signed(HALF);
      sum[i] = $signed({{3{a_r[i][PW-1]}}, a_r[i]}) + $signed(rnd[i][PRODW-1:TFB]);
      pts_b_nxt[i] = act_r ? sum[i][PW-1:0] : a_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (ready_a) begin
        va_r <= up_valid;
      end
      if (ready_b) begin
        vb_r <= va_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && up_valid) begin
      act_r   <= (up_deg > DEG_W'(LEVEL));
      deg_a_r <= up_deg;
      t_a_r   <= up_t;
      a_r     <= up_pts[NL-1:0];
      for (int i = 0; i < NL; i++) begin
        prod_r[i] <= prod_nxt[i];
      end
    end
    if (ready_b && va_r) begin
      deg_b_r <= deg_a_r;
      t_b_r   <= t_a_r;
      pts_b_r <= pts_b_nxt;
    end
  end

  assign dn_valid = vb_r;
  assign dn_pts   = pts_b_r;
  assign dn_deg   = deg_b_r;
  assign dn_t     = t_b_r;

endmodule

`default_nettype wire

>>> rtl/bezier_point_eval.sv
// Bezier point evaluator top level: input clamping, chain of de Casteljau rounds.
// Depends on bpe_pkg, bpe_if (bpe_in_if, bpe_out_if) and bpe_level.
`timescale 1ns / 1ps
`default_nettype none

// Evaluates one coordinate of a Bezier curve of degree 1 to MAX_DEGREE at t by de
// Casteljau's scheme. Points and result are signed POINT_WIDTH-bit fixed point, t is
// unsigned with T_FRAC_BITS fraction bits where 2^T_FRAC_BITS is 1.0; each
// interpolation rounds to nearest, ties upward. The block accepts one transaction per
// cycle while the output is not stalled. Every round of interpolation takes two
// register stages, one for the difference-times-t multiplies and one for the rounding
// add, and all MAX_DEGREE rounds are always traversed, with rounds beyond the
// requested degree passing points unchanged. Each stage holds its transaction under
// back-pressure and empty stages close up. A degree of zero is treated as one, a
// degree above MAX_DEGREE as MAX_DEGREE, and a t above 1.0 as 1.0.
module bezier_point_eval
  import bpe_pkg::*;
#(
  parameter int POINT_WIDTH = 32,
  parameter int T_FRAC_BITS = 16,
  parameter int MAX_DEGREE  = 6
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bpe_in_if.sink     in_ch,
  bpe_out_if.source  out_ch
);

  localparam int PW  = POINT_WIDTH;
  localparam int TFB = T_FRAC_BITS;
  localparam logic [TFB:0] T_ONE = {1'b1, {TFB{1'b0}}};

  logic [NUM_POINTS-1:0][PW-1:0] p_all;
  deg_t                          deg_in;
  logic [TFB:0]                  t_in;

  logic [MAX_DEGREE:0][PW-1:0]   pts_c   [MAX_DEGREE+1];
  logic                          valid_c [MAX_DEGREE+1];
  logic                          ready_c [MAX_DEGREE+1];
  deg_t                          deg_c   [MAX_DEGREE+1];
  logic [TFB:0]                  t_c     [MAX_DEGREE+1];

  assign p_all[0] = in_ch.p0;
  assign p_all[1] = in_ch.p1;
  assign p_all[2] = in_ch.p2;
  assign p_all[3] = in_ch.p3;
  assign p_all[4] = in_ch.p4;
  assign p_all[5] = in_ch.p5;
  assign p_all[6] = in_ch.p6;

  always_comb begin
    if (in_ch.degree == deg_t'(0)) begin
      deg_in = deg_t'(1);
    end else if (in_ch.degree > deg_t'(MAX_DEGREE)) begin
      deg_in = deg_t'(MAX_DEGREE);
    end else begin
      deg_in = in_ch.degree;
    end
    t_in = in_ch.param_t[TFB] ? T_ONE : in_ch.param_t;
  end

  assign valid_c[0] = in_ch.valid;
  assign in_ch.ready = ready_c[0];
  assign deg_c[0]   = deg_in;
  assign t_c[0]     = t_in;
  assign pts_c[0]   = p_all[MAX_DEGREE:0];

  for (genvar l = 0; l < MAX_DEGREE; l++) begin : g_lvl
    localparam int NPTS = MAX_DEGREE + 1 - l;

    bpe_level #(
      .PW    (PW),
      .TFB   (TFB),
      .LEVEL (l),
      .NPTS  (NPTS)
    ) u_level (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (valid_c[l]),
      .up_ready (ready_c[l]),
      .up_pts   (pts_c[l][NPTS-1:0]),
      .up_deg   (deg_c[l]),
      .up_t     (t_c[l]),
      .dn_valid (valid_c[l+1]),
      .dn_ready (ready_c[l+1]),
      .dn_pts   (pts_c[l+1][NPTS-2:0]),
      .dn_deg   (deg_c[l+1]),
      .dn_t     (t_c[l+1])
    );

    assign pts_c[l+1][MAX_DEGREE:NPTS-1] = '0;
  end

  assign out_ch.valid       = valid_c[MAX_DEGREE];
  assign ready_c[MAX_DEGREE] = out_ch.ready;
  assign out_ch.curve_value = pts_c[MAX_DEGREE][0];

  // With the sink taking results, every stage drains and the input is open.
  assert property (@(posedge clk) disable iff (!rst_n) out_ch.ready |-> in_ch.ready)
    else $error("input stalled while the output is being drained");

  // Reset empties the pipeline.
  assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

  // Just after reset no result is valid yet, as no transaction can have crossed all stages.
  assert property (@(posedge clk) $past(!rst_n, 1) |=> !out_ch.valid)
    else $error("result valid too soon after reset");

endmodule

`default_nettype wire

>>> tb/bezier_point_eval_tb.sv
// Self-checking testbench for bezier_point_eval: drives curve evaluations and compares
// every result with a de Casteljau predictor computed here in 64-bit integer arithmetic.
// Depends on rtl/bpe_pkg.sv, rtl/bpe_if.sv and the bezier_point_eval RTL.
`timescale 1ns / 1ps

module bezier_point_eval_tb;
  import bpe_pkg::*;

  localparam int PW      = 32;
  localparam int TF      = 16;
  localparam int MAXD    = 6;
  localparam int LATENCY = 2 * MAXD;

  localparam logic [PW-1:0] PMAX  = 32'h7fff_ffff;
  localparam logic [PW-1:0] PMIN  = 32'h8000_0000;
  localparam logic [TF:0]   T_ONE = 17'h1_0000;
  localparam logic [TF:0]   T_HALF_PT = 17'h0_8000;
  localparam logic [TF:0]   T_TOP = 17'h1_ffff;

  typedef struct packed {
    deg_t                             degree;
    logic [NUM_POINTS-1:0][PW-1:0]    pts;
    logic [TF:0]                      param_t;
  } curve_req_t;

  logic clk;
  logic rst_n;

  bpe_in_if  #(.POINT_WIDTH(PW), .T_FRAC_BITS(TF)) in_ch ();
  bpe_out_if #(.POINT_WIDTH(PW))                   out_ch ();

  bezier_point_eval #(
    .POINT_WIDTH(PW),
    .T_FRAC_BITS(TF),
    .MAX_DEGREE (MAXD)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  logic signed [PW-1:0] curve_expected[$];
  logic signed [PW-1:0] expected_value;
  int unsigned          src_idle_pct;
  int unsigned          sink_stall_pct;
  int unsigned          hold_left;
  int unsigned          err_count;
  int unsigned          sent_count;
  int unsigned          checked_count;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // De Casteljau evaluation; floor((d*t + S/2) / S) is exact in 64 bits since |d| < 2^33.
  function automatic logic signed [PW-1:0] eval_curve(input curve_req_t req);
    longint pts[NUM_POINTS];
    longint tv;
    longint diff;
    int     order;
    order = int'(req.degree);
    if (order < 1) order = 1;
    if (order > MAXD) order = MAXD;
    tv = (req.param_t > T_ONE) ? longint'(T_ONE) : longint'(req.param_t);
    for (int i = 0; i < NUM_POINTS; i++) pts[i] = longint'($signed(req.pts[i]));
    for (int lvl = 0; lvl < order; lvl++) begin
      for (int i = 0; i < order - lvl; i++) begin
        diff   = pts[i+1] - pts[i];
        pts[i] = pts[i] + ((diff * tv + (longint'(1) <<< (TF - 1))) >>> TF);
      end
    end
    return pts[0][PW-1:0];
  endfunction

  function automatic logic [PW-1:0] rand_point();
    case ($urandom_range(0, 7))
      0:       return PMIN;
      1:       return PMAX;
      2:       return PW'($signed($urandom_range(0, 255)) - 128);
      default: return PW'($urandom);
    endcase
  endfunction

  function automatic curve_req_t rand_req();
    curve_req_t req;
    req.degree = deg_t'($urandom_range(0, 7));
    for (int i = 0; i < NUM_POINTS; i++) req.pts[i] = rand_point();
    case ($urandom_range(0, 9))
      0:       req.param_t = '0;
      1:       req.param_t = T_ONE;
      2:       req.param_t = (TF + 1)'($urandom);
      default: req.param_t = (TF + 1)'($urandom_range(0, 65536));
    endcase
    return req;
  endfunction

  // Called just after a rising edge (or after reset); drives the item at a falling edge after any random idle gaps.
  task automatic send_item(input curve_req_t req);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.degree  <= req.degree;
    in_ch.p0      <= req.pts[0];
    in_ch.p1      <= req.pts[1];
    in_ch.p2      <= req.pts[2];
    in_ch.p3      <= req.pts[3];
    in_ch.p4      <= req.pts[4];
    in_ch.p5      <= req.pts[5];
    in_ch.p6      <= req.pts[6];
    in_ch.param_t <= req.param_t;
    do @(posedge clk); while (!in_ch.ready);
    curve_expected.insert(curve_expected.size(), eval_curve(req));
    sent_count++;
  endtask

  task automatic send_points(input deg_t deg, input logic [TF:0] t,
                             input logic [NUM_POINTS-1:0][PW-1:0] pts);
    curve_req_t req;
    req.degree  = deg;
    req.param_t = t;
    req.pts     = pts;
    send_item(req);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (curve_expected.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [NUM_POINTS-1:0][PW-1:0] alt;
    logic [NUM_POINTS-1:0][PW-1:0] rnd;
    alt = {PMAX, PMIN, PMAX, PMIN, PMAX, PMIN, PMAX};
    rnd = {rand_point(), rand_point(), rand_point(), rand_point(),
           rand_point(), rand_point(), rand_point()};
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    // Endpoints of t pick out the first and last control point exactly.
    send_points(3'd1, '0, {rnd[6:2], PMIN, PMAX});
    send_points(3'd1, T_ONE, {rnd[6:2], PMIN, PMAX});
    // Ties round toward plus infinity; degree zero behaves as degree one.
    send_points(3'd0, T_HALF_PT, {rnd[6:2], 32'd1, 32'd0});
    send_points(3'd1, T_HALF_PT, {rnd[6:2], 32'hffff_ffff, 32'd0});
    send_points(3'd7, (TF + 1)'($urandom_range(0, 65536)), rnd);
    // Parameter values above one are clamped to one.
    send_points(3'd3, T_TOP, rnd);
    send_points(3'd2, T_ONE + 17'd1, rnd);
    send_points(3'd6, 17'd12345, {NUM_POINTS{PMIN}});
    send_points(3'd6, 17'd54321, {NUM_POINTS{PMAX}});
    send_points(3'd6, T_HALF_PT, alt);
    send_points(3'd6, 17'd1, alt);
    send_points(3'd6, T_ONE - 17'd1, alt);
    send_points(3'd5, '0, {PMIN, PMAX, 32'd5, 32'd4, 32'd3, 32'd2, 32'd1});
    send_points(3'd4, T_ONE, {PMIN, PMAX, 32'd5, 32'd4, 32'd3, 32'd2, 32'd1});
    for (int d = 1; d <= MAXD; d++) begin
      send_points(deg_t'(d), (TF + 1)'($urandom_range(0, 65536)),
                  {rand_point(), rand_point(), rand_point(), rand_point(),
                   rand_point(), rand_point(), rand_point()});
    end
    drain_results();
  endtask

  task automatic test_random(input int n, input int unsigned src_pct,
                             input int unsigned sink_pct);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    repeat (n) send_item(rand_req());
    drain_results();
  endtask

  // The receiver holds off long enough for the pipeline to fill and stall the input.
  task automatic test_backpressure();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    @(posedge clk);
    hold_left = 300;
    repeat (60) send_item(rand_req());
    drain_results();
  endtask

  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (curve_expected.size() == 0) begin
        $error("curve_value: unexpected result %0d with nothing pending",
               out_ch.curve_value);
        err_count++;
      end else begin
        expected_value = curve_expected.pop_front();
        checked_count++;
        if (out_ch.curve_value !== expected_value) begin
          $error("curve_value: expected %0d, actual %0d", expected_value,
                 out_ch.curve_value);
          err_count++;
        end
      end
    end
  end

  initial begin
    #(12 * 400000);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.degree   = '0;
    in_ch.p0       = '0;
    in_ch.p1       = '0;
    in_ch.p2       = '0;
    in_ch.p3       = '0;
    in_ch.p4       = '0;
    in_ch.p5       = '0;
    in_ch.p6       = '0;
    in_ch.param_t  = '0;
    out_ch.ready   = 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_left      = 0;
    err_count      = 0;
    sent_count     = 0;
    checked_count  = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(300, 20, 75);
    test_random(300, 75, 20);
    test_random(300, 0, 0);
    test_backpressure();

    if (curve_expected.size() != 0) begin
      $error("curve_value: %0d expected results never arrived", curve_expected.size());
      err_count++;
    end
    $display("Sent %0d curve evaluations (degree codes 0-7, t from 0 past 1.0), checked %0d.",
             sent_count, checked_count);
    $display("Traffic included sender gaps, receiver stalls and a long output hold-off.");
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> bezier_point_eval.f
rtl/bpe_pkg.sv
rtl/bpe_if.sv
rtl/bpe_level.sv
rtl/bezier_point_eval.sv
tb/bezier_point_eval_tb.sv
